>>> hw/rtl/frwa_pkg.sv
package frwa_pkg;

	// field widths fixed by the channel definitions
	localparam int unsigned TS_W      = 32;
	localparam int unsigned OUT_W     = 32;
	localparam int unsigned SAMPLES_W = 5;
	localparam int unsigned FRAC_W    = 8;

	// configuration port
	localparam int unsigned PADDR_W   = 3;
	localparam int unsigned REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_TPS = 1'b0;
	localparam logic [31:0] TPS_RESET = 32'd100000000;

	// saturated rate
	localparam logic [OUT_W-1:0] RATE_SAT = '1;

	// front sequencer
	typedef enum logic [1:0] {
		F_IDLE = 2'b01,
		F_UPD  = 2'b10
	} front_state_t;

	// back sequencer
	typedef enum logic [3:0] {
		B_IDLE     = 4'b0001,
		B_DIV_MEAN = 4'b0010,
		B_DIV_RATE = 4'b0100,
		B_DONE     = 4'b1000
	} back_state_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} frwa_qstat_t;

endpackage

>>> hw/rtl/frwa_if.sv
interface frwa_in_if;
	import frwa_pkg::*;
	logic            valid;
	logic            ready;
	logic [TS_W-1:0] timestamp;

	modport source (output valid, output timestamp, input ready);
	modport sink (input valid, input timestamp, output ready);
endinterface

interface frwa_out_if;
	import frwa_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [OUT_W-1:0]     mean_interval;
	logic [OUT_W-1:0]     frame_rate_q8;
	logic [SAMPLES_W-1:0] samples_held;

	modport source (output valid, output mean_interval, output frame_rate_q8,
		output samples_held, input ready);
	modport sink (input valid, input mean_interval, input frame_rate_q8,
		input samples_held, output ready);
endinterface

>>> hw/rtl/frwa_ram.sv
module frwa_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/frwa_front.sv
module frwa_front import frwa_pkg::*; #(
	parameter int unsigned WINDOW_DEPTH = 16,
	localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1),
	localparam int unsigned SUM_W  = TS_W + CNT_W,
	localparam int unsigned SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	frwa_in_if.sink          events,
	input  frwa_qstat_t      qstat,
	output logic             push,
	output logic [SUM_W-1:0] job_sum,
	output logic [CNT_W-1:0] job_cnt
);

	front_state_t      state_q;
	logic              seen_first_q;
	logic [TS_W-1:0]   prev_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  sum_q;
	logic [TS_W-1:0]   ts_s1;
	logic [TS_W-1:0]   old_dt;
	logic              accept;
	logic              full;
	logic [TS_W-1:0]   dt;
	logic [SUM_W-1:0]  sum_nx;
	logic [CNT_W-1:0]  count_nx;
	logic [SLOT_W-1:0] slot_nx;

	// take an item only when the queue can hold its job
	assign events.ready = (state_q == F_IDLE) && !qstat.full;
	assign accept       = events.valid && events.ready;

	// window update from the item held in the upper stage
	assign full     = (count_q == CNT_W'(WINDOW_DEPTH));
	assign dt       = ts_s1 - prev_q;
	assign sum_nx   = sum_q - (full ? SUM_W'(old_dt) : '0) + SUM_W'(dt);
	assign count_nx = full ? count_q : count_q + 1'b1;
	assign slot_nx  = (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;

	// interval ring
	frwa_ram #(
		.WIDTH (TS_W),
		.DEPTH (WINDOW_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (state_q == F_UPD && seen_first_q),
		.waddr (slot_q),
		.wdata (dt),
		.re    (accept),
		.raddr (slot_q),
		.rdata (old_dt)
	);

	// job to the back end
	always_comb begin
		push    = (state_q == F_UPD);
		job_sum = seen_first_q ? sum_nx : sum_q;
		job_cnt = seen_first_q ? count_nx : count_q;
	end

	// sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= F_IDLE;
			seen_first_q <= 1'b0;
			prev_q       <= '0;
			slot_q       <= '0;
			count_q      <= '0;
			sum_q        <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_UPD;
					end
				end
				F_UPD: begin
					state_q      <= F_IDLE;
					seen_first_q <= 1'b1;
					prev_q       <= ts_s1;
					if (seen_first_q) begin
						slot_q  <= slot_nx;
						count_q <= count_nx;
						sum_q   <= sum_nx;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// timestamp of the item in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			ts_s1 <= events.timestamp;
		end
	end

	// window bookkeeping stays in range
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(WINDOW_DEPTH))
		else $error("interval count beyond window depth");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SLOT_W'(WINDOW_DEPTH - 1))
		else $error("write slot beyond window depth");

	// count stays zero until the first event has been seen
	a_count_first: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_first_q |-> count_q == '0)
		else $error("intervals counted before first event");

endmodule

>>> hw/rtl/frwa_queue.sv
module frwa_queue import frwa_pkg::*; #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output frwa_qstat_t      qstat
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       fill_q;

	assign qstat.full  = (fill_q == 2'd2);
	assign qstat.empty = (fill_q == 2'd0);
	assign pop_data    = entry_q[rptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// entries
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

endmodule

>>> hw/rtl/frwa_back.sv
module frwa_back import frwa_pkg::*; #(
	parameter int unsigned WINDOW_DEPTH = 16,
	localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1),
	localparam int unsigned SUM_W  = TS_W + CNT_W,
	localparam int unsigned NUM_W  = TS_W + FRAC_W + CNT_W,
	localparam int unsigned STEP_W = $clog2(NUM_W)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [31:0]      tps,
	input  frwa_qstat_t      qstat,
	input  logic [SUM_W-1:0] job_sum,
	input  logic [CNT_W-1:0] job_cnt,
	output logic             pop,
	frwa_out_if.source       results
);

	back_state_t          state_q;
	logic                 out_valid_q;
	logic [SUM_W-1:0]     sum_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [TS_W+CNT_W-1:0] prod_q;
	logic [SUM_W-1:0]     den_q;
	logic [SUM_W-1:0]     rem_q;
	logic [NUM_W-1:0]     quo_q;
	logic [STEP_W-1:0]    step_q;
	logic [OUT_W-1:0]     mean_q;
	logic [OUT_W-1:0]     rate_q;
	logic [OUT_W-1:0]     mean_out_q;
	logic [OUT_W-1:0]     rate_out_q;
	logic [CNT_W+4:0]     cnt_out_q;
	logic [SUM_W:0]       rem_sh;
	logic [SUM_W:0]       rem_sub;
	logic                 ge;
	logic [SUM_W-1:0]     rem_nx;
	logic [NUM_W-1:0]     quo_nx;
	logic                 last_step;
	logic                 load_out;

	// one restoring division step per cycle
	assign rem_sh    = {rem_q, quo_q[NUM_W-1]};
	assign ge        = rem_sh >= {1'b0, den_q};
	assign rem_sub   = rem_sh - {1'b0, den_q};
	assign rem_nx    = ge ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
	assign quo_nx    = {quo_q[NUM_W-2:0], ge};
	assign last_step = (step_q == '0);

	assign pop      = (state_q == B_IDLE) && !qstat.empty;
	assign load_out = (state_q == B_DONE) && (!out_valid_q || results.ready);

	// result register
	assign results.valid         = out_valid_q;
	assign results.mean_interval = mean_out_q;
	assign results.frame_rate_q8 = rate_out_q;
	assign results.samples_held  = cnt_out_q[SAMPLES_W-1:0];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						state_q <= (job_cnt == '0) ? B_DONE : B_DIV_MEAN;
					end
				end
				B_DIV_MEAN: begin
					if (last_step) begin
						state_q <= (sum_q == '0) ? B_DONE : B_DIV_RATE;
					end
				end
				B_DIV_RATE: begin
					if (last_step) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (load_out) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// divider datapath and results
	always_ff @(posedge clk) begin
		prod_q <= tps * cnt_q;
		unique case (state_q)
			B_IDLE: begin
				sum_q  <= job_sum;
				cnt_q  <= job_cnt;
				quo_q  <= NUM_W'(job_sum);
				den_q  <= SUM_W'(job_cnt);
				rem_q  <= '0;
				step_q <= STEP_W'(NUM_W - 1);
				mean_q <= '0;
				rate_q <= '0;
			end
			B_DIV_MEAN: begin
				step_q <= step_q - 1'b1;
				rem_q  <= rem_nx;
				quo_q  <= quo_nx;
				if (last_step) begin
					mean_q <= quo_nx[OUT_W-1:0];
					rate_q <= RATE_SAT;
					quo_q  <= {prod_q, FRAC_W'(0)};
					den_q  <= sum_q;
					rem_q  <= '0;
					step_q <= STEP_W'(NUM_W - 1);
				end
			end
			B_DIV_RATE: begin
				step_q <= step_q - 1'b1;
				rem_q  <= rem_nx;
				quo_q  <= quo_nx;
				if (last_step) begin
					rate_q <= (quo_nx[NUM_W-1:OUT_W] != '0) ? RATE_SAT
						: quo_nx[OUT_W-1:0];
				end
			end
			B_DONE: begin
				if (load_out) begin
					mean_out_q <= mean_q;
					rate_out_q <= rate_q;
					cnt_out_q  <= (CNT_W + 5)'(cnt_q);
				end
			end
			default: begin
				step_q <= '0;
			end
		endcase
	end

	// the rate division never runs on an empty sum
	a_rate_den: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DIV_RATE |-> den_q != '0)
		else $error("rate division with zero sum");

	// an empty window always reports zero mean and rate
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DONE && cnt_q == '0) |-> (mean_q == '0 && rate_q == '0))
		else $error("nonzero result for empty window");

	// a pending result is never overwritten
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !results.ready) |=> $stable(mean_out_q))
		else $error("pending result overwritten");

endmodule

>>> hw/rtl/frame_rate_window_average.sv
// Frame rate meter over a moving window of frame intervals.
// events carries one timestamp per frame (free-running tick counter,
// wraps at 2^32); results returns one item per event: the mean interval
// in ticks, the frame rate in unsigned Q24.8 and the number of intervals
// held. The first event after reset only records its time and reports
// an empty window. ticks_per_second sits at APB address 0.
// The front end takes an item in its idle state and updates the interval ring
// (a RAM with registered read) in its update state, so it takes no new item
// before the update is done, and only while the two-entry job queue has room.
// The back end runs a one-bit-per-cycle restoring divider for the mean and
// then for the rate; its divisions set the sustained rate. For an empty
// window both divisions are skipped, for an all-zero sum only the rate one.
// A result waits in the output register while results.ready is low; the
// back end keeps working on the next job and the front keeps taking
// items until the queue fills, then events.ready drops.
// Reset clears the window, the first-event flag and restores
// ticks_per_second to 100000000.
module frame_rate_window_average import frwa_pkg::*; #(
	parameter int unsigned WINDOW_DEPTH = 16,
	localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1),
	localparam int unsigned SUM_W = TS_W + CNT_W
) (
	input  logic               clk,
	input  logic               arst_n,
	frwa_in_if.sink            events,
	frwa_out_if.source         results,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [31:0]          tps_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 push;
	logic                 pop;
	logic [SUM_W-1:0]     job_sum;
	logic [CNT_W-1:0]     job_cnt;
	logic [SUM_W-1:0]     q_sum;
	logic [CNT_W-1:0]     q_cnt;
	frwa_qstat_t          qstat;

	// register access
	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_TPS) begin
			prdata = tps_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
		end else if (psel && penable && pwrite && pready && reg_idx == REG_TPS) begin
			tps_q <= pwdata;
		end
	end

	// intake and window update
	frwa_front #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.events  (events),
		.qstat   (qstat),
		.push    (push),
		.job_sum (job_sum),
		.job_cnt (job_cnt)
	);

	// job queue between front and back
	frwa_queue #(
		.WIDTH (SUM_W + CNT_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({job_sum, job_cnt}),
		.pop       (pop),
		.pop_data  ({q_sum, q_cnt}),
		.qstat     (qstat)
	);

	// divisions and result register
	frwa_back #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.tps     (tps_q),
		.qstat   (qstat),
		.job_sum (q_sum),
		.job_cnt (q_cnt),
		.pop     (pop),
		.results (results)
	);

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import frwa_pkg::*;

	localparam int unsigned DEPTH = 16;
	localparam logic [PADDR_W-1:0] ADDR_TPS    = {REG_TPS, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_UNUSED = {~REG_TPS, 2'b00};
	localparam int unsigned DRAIN_CYCLES = 200;
	localparam logic [TS_W-1:0] CORNER_STAMPS [7] = '{
		32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
		32'h0000_000F, 32'h8000_0000, 32'h7FFF_FFFF
	};

	typedef struct packed {
		logic [OUT_W-1:0]     mean_interval;
		logic [OUT_W-1:0]     frame_rate_q8;
		logic [SAMPLES_W-1:0] samples_held;
	} frame_stats_t;

	// running window of frame intervals and the stats each item should produce
	class window_average_tracker;
		logic [31:0]      tick_rate;
		bit               have_first;
		logic [TS_W-1:0]  last_stamp;
		logic [31:0]      intervals [DEPTH];
		int unsigned      slot;
		int unsigned      held;
		logic [63:0]      total;
		frame_stats_t     expected_stats [$];
		int unsigned      errors;

		function new();
			tick_rate  = TPS_RESET;
			have_first = 1'b0;
			last_stamp = '0;
			slot       = 0;
			held       = 0;
			total      = '0;
			errors     = 0;
		endfunction

		function void set_tick_rate(logic [31:0] value);
			tick_rate = value;
		endfunction

		function void note_event(logic [TS_W-1:0] stamp);
			logic [31:0]  dt;
			logic [63:0]  numer;
			logic [63:0]  quot;
			frame_stats_t stats;
			// first item only records the time
			if (!have_first) begin
				have_first = 1'b1;
				last_stamp = stamp;
			end else begin
				dt = stamp - last_stamp;
				// full window drops the oldest interval from the sum
				if (held >= DEPTH)
					total = total - intervals[slot];
				else
					held++;
				intervals[slot] = dt;
				total = total + dt;
				slot = (slot + 1) % DEPTH;
				last_stamp = stamp;
			end
			stats = '0;
			if (held > 0) begin
				quot = total / held;
				stats.mean_interval = quot[OUT_W-1:0];
				// all-zero intervals give the largest rate
				if (total == 0) begin
					stats.frame_rate_q8 = RATE_SAT;
				end else begin
					numer = {32'd0, tick_rate} << FRAC_W;
					numer = numer * held;
					quot = numer / total;
					if (quot > 64'hFFFF_FFFF)
						stats.frame_rate_q8 = RATE_SAT;
					else
						stats.frame_rate_q8 = quot[OUT_W-1:0];
				end
			end
			stats.samples_held = held[SAMPLES_W-1:0];
			expected_stats.push_back(stats);
		endfunction

		function void field_check(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			end
		endfunction

		function void check_result(frame_stats_t got);
			frame_stats_t want;
			if (expected_stats.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, actual mean %h rate %h held %0d",
					$time, got.mean_interval, got.frame_rate_q8, got.samples_held);
				return;
			end
			want = expected_stats.pop_front();
			field_check("mean_interval", want.mean_interval, got.mean_interval);
			field_check("frame_rate_q8", want.frame_rate_q8, got.frame_rate_q8);
			field_check("samples_held", 32'(want.samples_held), 32'(got.samples_held));
		endfunction

		function int unsigned pending();
			return expected_stats.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	bit                 steady;
	logic [TS_W-1:0]    stamp_now;

	window_average_tracker tracker = new();

	frwa_in_if  events_ch();
	frwa_out_if results_ch();

	frame_rate_window_average dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.events  (events_ch),
		.results (results_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// idle cycles before an item: mostly none, some short, a few long
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 4);
		else
			return $urandom_range(20, 120);
	endfunction

	// one frame event; valid stays up if the next item follows at once
	task send_event(input logic [TS_W-1:0] stamp);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			events_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		events_ch.valid     <= 1'b1;
		events_ch.timestamp <= stamp;
		do @(posedge clk); while (!events_ch.ready);
		tracker.note_event(stamp);
		stamp_now = stamp;
	endtask

	// apb write: setup then access
	task write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_TPS)
			tracker.set_tick_rate(data);
	endtask

	// stop sending and wait for every outstanding result
	task settle();
		events_ch.valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	// corners: empty window, zero interval, saturated rate, wrap, max intervals
	task directed_events();
		foreach (CORNER_STAMPS[k])
			send_event(CORNER_STAMPS[k]);
		repeat (14) send_event(stamp_now + 32'hFFFF_FFFF);
		repeat (3) send_event(stamp_now + 32'd1666667);
	endtask

	// random frame timing with occasional runs of a fixed interval
	task run_random(input int unsigned count);
		int unsigned run_left;
		logic [31:0] run_dt;
		int unsigned r;
		run_left = 0;
		run_dt   = '0;
		for (int unsigned i = 0; i < count; i++) begin
			steady = (i < 40);
			if (run_left > 0) begin
				run_left--;
				send_event(stamp_now + run_dt);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 5) begin
					run_left = $urandom_range(16, 24);
					run_dt = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(1, 1 << 24);
					send_event(stamp_now + run_dt);
				end else if (r < 35)
					send_event(stamp_now + $urandom_range(1, 1000));
				else if (r < 50)
					send_event(stamp_now + $urandom_range(0, 1 << 20));
				else if (r < 57)
					send_event(stamp_now);
				else if (r < 70)
					send_event($urandom());
				else if (r < 82)
					send_event(stamp_now + $urandom());
				else
					send_event(stamp_now + $urandom_range(100000, 5000000));
			end
		end
		steady = 1'b0;
	endtask

	// result side: check accepted items, stall at random
	initial begin
		int unsigned  stall_left;
		int unsigned  r;
		frame_stats_t got;
		stall_left = 0;
		results_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (results_ch.valid && results_ch.ready) begin
				got.mean_interval = results_ch.mean_interval;
				got.frame_rate_q8 = results_ch.frame_rate_q8;
				got.samples_held  = results_ch.samples_held;
				tracker.check_result(got);
			end
			if (steady) begin
				stall_left = 0;
				results_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				results_ch.ready <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 75) begin
					results_ch.ready <= 1'b1;
				end else begin
					stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(20, 120);
					results_ch.ready <= 1'b0;
				end
			end
		end
	end

	// main sequence
	initial begin
		logic [31:0] tps;
		arst_n              <= 1'b0;
		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= '0;
		pwdata              <= '0;
		events_ch.valid     <= 1'b0;
		events_ch.timestamp <= '0;
		steady    = 1'b0;
		stamp_now = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// a write to an unused index must leave the tick rate alone
		write_reg(ADDR_UNUSED, $urandom());
		directed_events();
		run_random(200);

		// sweep the tick rate, extremes first
		for (int k = 0; k < 5; k++) begin
			case (k)
				0: tps = 32'd1;
				1: tps = 32'hFFFF_FFFF;
				2: tps = $urandom_range(1, 32'hFFFF_FFFF);
				3: tps = 32'd1000;
				default: tps = 32'd27000000;
			endcase
			settle();
			write_reg(ADDR_TPS, tps);
			run_random(190);
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// hang guard
	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
